FILE: rtl/depth_insertion_sort_core_defines.svh
// Assertion macros for the depth sort core.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef DEPTH_INSERTION_SORT_CORE_DEFINES_SVH
`define DEPTH_INSERTION_SORT_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define DIS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DIS_ASSERT_IMPL(lbl, ante, cons, msg)
`define DIS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/dis_pkg.sv
`timescale 1ns / 1ps

package dis_pkg;

  // Fixed field widths of the item ports.
  localparam int TAG_W      = 6;
  localparam int PORT_KEY_W = 32;

  // Record store port controls.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctl_t;

endpackage

FILE: rtl/dis_store.sv
`timescale 1ns / 1ps

// Record store: key and tag arrays, one write and one registered read per cycle.
module dis_store
  import dis_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int KEY_W = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  ram_ctl_t         ctl,
  input  logic [AW-1:0]    wr_addr,
  input  logic [KEY_W-1:0] wr_key,
  input  logic [TAG_W-1:0] wr_tag,
  input  logic [AW-1:0]    rd_addr,
  output logic [KEY_W-1:0] rd_key,
  output logic [TAG_W-1:0] rd_tag
);

  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [TAG_W-1:0] tag_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      key_mem[wr_addr] <= wr_key;
      tag_mem[wr_addr] <= wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_tag <= tag_mem[rd_addr];
    end
  end

endmodule

FILE: rtl/depth_insertion_sort_core.sv
`timescale 1ns / 1ps

// Channel | Signals                                         | Direction
// --------+-------------------------------------------------+-----------
// in      | in_valid, in_stall, depth_key, record_tag,       | sink
//         | last_item                                       |
// out     | out_valid, out_stall, sorted_key, sorted_tag,    | source
//         | last_result, overflow                           |
//
// Steps: an item that moves s stored records ahead of it goes through S_READ and
//   S_CMP for each of them (one read, one compare-and-write per step), and at the
//   front S_READ writes it in directly; a dropped item takes no step.
//   The item marked last then starts the emit pass, S_EMIT_RD then S_EMIT_LD per result.
// Reset: rst (synchronous) empties the batch and clears the batch's drop flag; store not cleared.
// Stalls: in_stall is high while busy; out_stall holds the output register and
//   the emit pass, and a batch's final result may wait while the next item is taken.
`include "depth_insertion_sort_core_defines.svh"

module depth_insertion_sort_core
  import dis_pkg::*;
#(
  parameter int MAX_RECORDS = 64,
  parameter int KEY_BITS    = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  // input items
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [PORT_KEY_W-1:0] depth_key,
  input  logic        [TAG_W-1:0]      record_tag,
  input  logic                         last_item,
  // result items
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [PORT_KEY_W-1:0] sorted_key,
  output logic        [TAG_W-1:0]      sorted_tag,
  output logic                         last_result,
  output logic                         overflow
);

  localparam int AW    = $clog2(MAX_RECORDS);
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,  // waiting for an item
    S_READ    = 5'b00010,  // read the neighbor below the hole
    S_CMP     = 5'b00100,  // compare; shift neighbor up or drop record in
    S_EMIT_RD = 5'b01000,  // read next sorted record once output is free
    S_EMIT_LD = 5'b10000   // load it into the output register
  } state_t;

  state_t state;

  logic [CNT_W-1:0]    count;     // records held in this batch
  logic                ovf;       // a record of this batch was dropped
  logic [CNT_W-1:0]    pos;       // current hole position
  logic [CNT_W-1:0]    idx;       // emit index
  logic [KEY_BITS-1:0] new_key;
  logic [TAG_W-1:0]    new_tag;
  logic                new_last;

  logic [KEY_BITS-1:0] out_key;

  // Store interface
  ram_ctl_t            ram_ctl;
  logic [AW-1:0]       wr_addr;
  logic [KEY_BITS-1:0] wr_key;
  logic [TAG_W-1:0]    wr_tag;
  logic [AW-1:0]       rd_addr;
  logic [KEY_BITS-1:0] rd_key;
  logic [TAG_W-1:0]    rd_tag;

  logic [KEY_BITS-1:0] key_in;
  logic [CNT_W-1:0]    pos_dec;
  logic                shift_up;
  logic                out_free;
  logic                emit_final;
  logic                store_full;

  // Key ingress: keep KEY_BITS bits; wider stores see the port zero-extended.
  // Egress: sign-extend narrow keys, truncate wide ones to the port.
  generate
    if (KEY_BITS > PORT_KEY_W) begin : g_wide
      assign key_in     = {{(KEY_BITS - PORT_KEY_W){1'b0}}, depth_key};
      assign sorted_key = out_key[PORT_KEY_W-1:0];
    end else if (KEY_BITS == PORT_KEY_W) begin : g_same
      assign key_in     = depth_key;
      assign sorted_key = out_key;
    end else begin : g_narrow
      assign key_in     = depth_key[KEY_BITS-1:0];
      assign sorted_key = {{(PORT_KEY_W - KEY_BITS){out_key[KEY_BITS-1]}}, out_key};
    end
  endgenerate

  assign in_stall   = (state != S_IDLE);
  assign pos_dec    = pos - CNT_W'(1);
  assign out_free   = !out_valid || !out_stall;
  assign emit_final = ((idx + CNT_W'(1)) == count);
  assign store_full = (count == CNT_W'(MAX_RECORDS));

  // Shared comparator: stored neighbor strictly below the new key moves up,
  // so equal keys keep arrival order.
  assign shift_up = (state == S_CMP) && ($signed(rd_key) < $signed(new_key));

  always_comb begin
    ram_ctl       = '0;
    ram_ctl.rd_en = ((state == S_READ) && (pos != '0)) ||
                    ((state == S_EMIT_RD) && out_free);
    ram_ctl.wr_en = ((state == S_READ) && (pos == '0)) || (state == S_CMP);
    wr_addr       = pos[AW-1:0];
    wr_key        = shift_up ? rd_key : new_key;
    wr_tag        = shift_up ? rd_tag : new_tag;
    rd_addr       = (state == S_EMIT_RD) ? idx[AW-1:0] : pos_dec[AW-1:0];
  end

  dis_store #(
    .DEPTH (MAX_RECORDS),
    .KEY_W (KEY_BITS)
  ) u_store (
    .clk     (clk),
    .ctl     (ram_ctl),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .wr_tag  (wr_tag),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_tag  (rd_tag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      pos       <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            new_key  <= key_in;
            new_tag  <= record_tag;
            new_last <= last_item;
            idx      <= '0;
            if (store_full) begin
              // drop the record; a dropped last item still closes the batch
              ovf <= 1'b1;
              if (last_item) begin
                state <= S_EMIT_RD;
              end
            end else begin
              pos   <= count;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (pos == '0) begin
            count <= count + CNT_W'(1);
            state <= new_last ? S_EMIT_RD : S_IDLE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (shift_up) begin
            pos   <= pos_dec;
            state <= S_READ;
          end else begin
            count <= count + CNT_W'(1);
            state <= new_last ? S_EMIT_RD : S_IDLE;
          end
        end
        S_EMIT_RD: begin
          if (out_free) begin
            state <= S_EMIT_LD;
          end
        end
        S_EMIT_LD: begin
          out_key     <= rd_key;
          sorted_tag  <= rd_tag;
          last_result <= emit_final;
          overflow    <= ovf;
          out_valid   <= 1'b1;
          if (emit_final) begin
            count <= '0;
            ovf   <= 1'b0;
            state <= S_IDLE;
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_EMIT_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A pending result is never overwritten by the emit pass.
  `DIS_ASSERT_IMPL(a_no_overwrite, state == S_EMIT_LD, !out_valid,
                   "emit load while output register still full")
  // Closing a batch empties it.
  `DIS_ASSERT_NEXT(a_batch_closed, (state == S_EMIT_LD) && emit_final,
                   (count == '0) && !ovf, "batch not cleared after final result")
  // Records are dropped only when the store is full.
  `DIS_ASSERT_IMPL(a_ovf_full, ovf, store_full, "overflow flagged below capacity")
  // The hole never sits above the fill level during insertion.
  `DIS_ASSERT_IMPL(a_pos_range, (state == S_READ) || (state == S_CMP),
                   (pos <= count) && !store_full, "insertion position out of range")

endmodule

FILE: tb/tb_depth_insertion_sort_core.sv
`timescale 1ns / 1ps

module tb_depth_insertion_sort_core;
  import dis_pkg::*;

  // DUT configuration; the prediction below follows these
  localparam int MAX_RECORDS = 64;
  localparam int KEY_BITS    = 32;

  // worst busy stretch: one insertion plus both idle draws, with margin
  localparam int WATCHDOG_LIMIT = 20 * (2 * MAX_RECORDS + 2 + 2 * 16);
  // settle window after the last result: one full insertion and then some
  localparam int DRAIN_CYCLES   = 2 * (2 * MAX_RECORDS + 2);
  localparam int RANDOM_ITEMS   = 135;
  localparam int MAX_IDLE       = 16;
  localparam int MAX_REPORTS    = 10;

  // how keys of one batch are drawn
  typedef enum int {
    KEY_RANDOM,
    KEY_TIES,
    KEY_EXTREME,
    KEY_NARROW
  } key_mode_t;

  // one sorted result as it should leave the block
  typedef struct packed {
    logic signed [PORT_KEY_W-1:0] key;
    logic        [TAG_W-1:0]      tag;
    logic                         last;
    logic                         ovf;
  } sorted_rec_t;

  // Scoreboard: keeps its own copy of the batch store, insertion-sorted as
  // records are accepted, and queues the sorted batch when the last one lands.
  class depth_sort_scoreboard;
    logic signed [63:0]   batch_key [MAX_RECORDS];
    logic [TAG_W-1:0]     batch_tag [MAX_RECORDS];
    int                   batch_count;
    bit                   batch_dropped;
    sorted_rec_t          sorted_due [$];
    int                   mismatches;
    int                   records_seen;
    int                   batches_closed;
    int                   dropped_batches;
    int                   results_checked;

    function new();
      batch_count     = 0;
      batch_dropped   = 0;
      mismatches      = 0;
      records_seen    = 0;
      batches_closed  = 0;
      dropped_batches = 0;
      results_checked = 0;
    endfunction

    // key as the block compares it: low KEY_BITS, sign-extended
    function logic signed [63:0] compare_key(logic [PORT_KEY_W-1:0] raw);
      logic signed [63:0] wide;
      wide = {{(64 - PORT_KEY_W){raw[PORT_KEY_W-1]}}, raw};
      wide = wide <<< (64 - KEY_BITS);
      wide = wide >>> (64 - KEY_BITS);
      return wide;
    endfunction

    function int pending();
      return sorted_due.size();
    endfunction

    function void note_record(logic [PORT_KEY_W-1:0] raw, logic [TAG_W-1:0] tag,
                              logic last);
      logic signed [63:0] wide;
      sorted_rec_t        rec;
      int                 pos;
      int                 i;
      records_seen++;
      wide = compare_key(raw);
      if (batch_count >= MAX_RECORDS) begin
        batch_dropped = 1;
      end else begin
        // move ahead of strictly smaller keys only, so ties stay in order
        pos = batch_count;
        while (pos > 0 && batch_key[pos-1] < wide) begin
          batch_key[pos] = batch_key[pos-1];
          batch_tag[pos] = batch_tag[pos-1];
          pos--;
        end
        batch_key[pos] = wide;
        batch_tag[pos] = tag;
        batch_count++;
      end
      if (last) begin
        for (i = 0; i < batch_count; i++) begin
          rec.key  = batch_key[i][PORT_KEY_W-1:0];
          rec.tag  = batch_tag[i];
          rec.last = (i == batch_count - 1);
          rec.ovf  = batch_dropped;
          sorted_due.push_back(rec);
        end
        batches_closed++;
        if (batch_dropped) dropped_batches++;
        batch_count   = 0;
        batch_dropped = 0;
      end
    endfunction

    function void check_result(logic [PORT_KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                               logic last, logic ovf);
      sorted_rec_t want;
      results_checked++;
      if (sorted_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected result: key=%0d tag=%0d last=%0b ovf=%0b",
                   $realtime, $signed(key), tag, last, ovf);
        return;
      end
      want = sorted_due.pop_front();
      if (want.key !== key || want.tag !== tag || want.last !== last ||
          want.ovf !== ovf) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result mismatch: exp key=%0d tag=%0d last=%0b ovf=%0b, %s",
                   $realtime, $signed(want.key), want.tag, want.last, want.ovf,
                   $sformatf("got key=%0d tag=%0d last=%0b ovf=%0b",
                             $signed(key), tag, last, ovf));
      end
    endfunction
  endclass

  // DUT ports, all driven inputs known from time zero
  logic                         clk         = 1'b0;
  logic                         rst         = 1'b1;
  logic                         in_valid    = 1'b0;
  logic                         in_stall;
  logic signed [PORT_KEY_W-1:0] depth_key   = '0;
  logic        [TAG_W-1:0]      record_tag  = '0;
  logic                         last_item   = 1'b0;
  logic                         out_valid;
  logic                         out_stall   = 1'b0;
  logic signed [PORT_KEY_W-1:0] sorted_key;
  logic        [TAG_W-1:0]      sorted_tag;
  logic                         last_result;
  logic                         overflow;

  depth_sort_scoreboard sb = new();

  // per-batch: no idling on either side while set
  bit                           calm_phase = 1'b0;
  // a few keys per batch reused to force ties
  logic        [PORT_KEY_W-1:0] tie_pool [3];

  depth_insertion_sort_core #(
    .MAX_RECORDS (MAX_RECORDS),
    .KEY_BITS    (KEY_BITS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .depth_key   (depth_key),
    .record_tag  (record_tag),
    .last_item   (last_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sorted_key  (sorted_key),
    .sorted_tag  (sorted_tag),
    .last_result (last_result),
    .overflow    (overflow)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Drive one item. Called right after a rising edge; valid stays up across
  // back-to-back items, dropped only when an idle gap is drawn.
  task automatic send_record(logic [PORT_KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                             logic last);
    int idle;
    idle = calm_phase ? 0 : $urandom_range(0, MAX_IDLE);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid   <= 1'b1;
    depth_key  <= key;
    record_tag <= tag;
    last_item  <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_record(key, tag, last);
  endtask

  function automatic logic [PORT_KEY_W-1:0] next_key(key_mode_t mode);
    logic [PORT_KEY_W-1:0] k;
    case (mode)
      KEY_TIES:    k = tie_pool[$urandom_range(0, 2)];
      KEY_EXTREME: begin
        case ($urandom_range(0, 5))
          0:       k = {1'b0, {(PORT_KEY_W-1){1'b1}}};   // most positive
          1:       k = {1'b1, {(PORT_KEY_W-1){1'b0}}};   // most negative
          2:       k = '0;
          3:       k = '1;
          4:       k = 1;
          default: k = $urandom;
        endcase
      end
      KEY_NARROW:  k = $urandom_range(0, 16) - 8;
      default:     k = $urandom;
    endcase
    return k;
  endfunction

  // One batch of random records; last flag on the final one only. Sizes
  // above MAX_RECORDS exercise the drop path.
  task automatic send_batch(int size, key_mode_t mode);
    int i;
    calm_phase = ($urandom_range(0, 3) == 0);
    for (i = 0; i < 3; i++) tie_pool[i] = $urandom;
    for (i = 0; i < size; i++)
      send_record(next_key(mode), TAG_W'($urandom_range(0, (1 << TAG_W) - 1)),
                  i == size - 1);
  endtask

  // Result side backpressure: draw a stall length per result, then take it.
  initial begin
    int hold;
    forever begin
      hold = calm_phase ? 0 : $urandom_range(0, MAX_IDLE);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && rst === 1'b0));
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(sorted_key, sorted_tag, last_result, overflow);
  end

  // Watchdog: too long with no item moving on either side ends the run
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst === 1'b1 || (in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles, %0d results still due",
               $realtime, idle_cycles, sb.pending());
      $display("** depth_insertion_sort_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int        random_items;
    int        batch_idx;
    int        full_at;
    int        ovf_at;
    int        size;
    key_mode_t mode;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // -- directed --
    calm_phase = 1'b0;
    // single-record batches at both key extremes and both tag extremes
    send_record(32'h7FFF_FFFF, 6'd63, 1'b1);
    send_record(32'h8000_0000, 6'd0, 1'b1);
    // mixed signs and extremes in one batch
    send_record(32'h0000_0000, 6'd1, 1'b0);
    send_record(32'hFFFF_FFFF, 6'd2, 1'b0);
    send_record(32'h0000_0001, 6'd3, 1'b0);
    send_record(32'h7FFF_FFFF, 6'd4, 1'b0);
    send_record(32'h8000_0000, 6'd5, 1'b1);
    // equal keys must keep arrival order
    send_record(32'd5, 6'd10, 1'b0);
    send_record(32'd5, 6'd11, 1'b0);
    send_record(-32'sd3, 6'd12, 1'b0);
    send_record(32'd5, 6'd13, 1'b0);
    send_record(-32'sd3, 6'd14, 1'b1);
    // ascending arrival: each record shifts the whole store
    send_record(-32'sd100, 6'd20, 1'b0);
    send_record(-32'sd50, 6'd21, 1'b0);
    send_record(32'd50, 6'd22, 1'b0);
    send_record(32'd100, 6'd23, 1'b1);
    // already descending: nothing shifts
    send_record(32'h0003_0000, 6'd30, 1'b0);
    send_record(32'h0002_8000, 6'd31, 1'b0);
    send_record(32'hFFFF_0000, 6'd32, 1'b1);
    // alternating bit patterns
    send_record(32'hAAAA_5555, 6'd42, 1'b0);
    send_record(32'h5555_AAAA, 6'd21, 1'b1);

    // -- random batches: mostly small, one exactly full, one overfull --
    random_items = 0;
    batch_idx    = 0;
    full_at      = $urandom_range(1, 3);
    ovf_at       = $urandom_range(1, 3);
    while (random_items < RANDOM_ITEMS || batch_idx <= full_at || batch_idx <= ovf_at) begin
      mode = key_mode_t'($urandom_range(0, 3));
      if (batch_idx == full_at) begin
        send_batch(MAX_RECORDS, mode);
        random_items += MAX_RECORDS;
      end
      if (batch_idx == ovf_at) begin
        size = MAX_RECORDS + 1 + $urandom_range(0, 2);
        send_batch(size, mode);
        random_items += size;
      end
      size = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      send_batch(size, mode);
      random_items += size;
      batch_idx++;
    end
    in_valid   <= 1'b0;
    calm_phase = 1'b0;

    // wait for every sorted result, then give any stray output a chance
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d records in %0d batches, %0d of them overfull",
             sb.records_seen, sb.batches_closed, sb.dropped_batches);
    $display("%0d sorted results checked, %0d mismatches, %0d results never seen",
             sb.results_checked, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** depth_insertion_sort_core: PASSED **");
    end else begin
      $display("** depth_insertion_sort_core: FAILED **");
    end
    $finish;
  end

endmodule
